@@ sv/at_slp_pkg.sv @@
package at_slp_pkg;

  localparam int PREFIX_LEN = 8;
  localparam logic [7:0] SCAN_PREFIX [PREFIX_LEN] = '{
    8'h2B, 8'h43, 8'h57, 8'h4C, 8'h41, 8'h50, 8'h3A, 8'h28
  };

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Field numbers inside one record
  localparam logic [2:0] F_ENCRYPTION = 3'd0;
  localparam logic [2:0] F_NAME       = 3'd1;
  localparam logic [2:0] F_SIGNAL     = 3'd2;
  localparam logic [2:0] F_STATION    = 3'd3;
  localparam logic [2:0] F_CHANNEL    = 3'd4;
  localparam logic [2:0] F_OFFSET     = 3'd5;
  localparam logic [2:0] FIELD_COUNT  = 3'd6;

  localparam logic [1:0] SLOT_ENCRYPTION = 2'd0;
  localparam logic [1:0] SLOT_SIGNAL     = 2'd1;
  localparam logic [1:0] SLOT_CHANNEL    = 2'd2;
  localparam logic [1:0] SLOT_OFFSET     = 2'd3;

  localparam logic [15:0] NUM_CAP = 16'h8000;
  localparam logic [15:0] NUM_MAX = 16'h7FFF;
  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  localparam int OUT_TEXT_BYTES = 32;
  localparam int TEXT_BITS      = OUT_TEXT_BYTES * 8;
  localparam logic [2:0] LAST_WORD = 3'd7;

  typedef enum logic [2:0] {
    PH_BLANK  = 3'b001,
    PH_DIGITS = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  typedef struct packed {
    logic                 kind;
    logic [15:0]          encryption;
    logic [15:0]          signal_strength;
    logic [15:0]          channel;
    logic [15:0]          freq_offset;
    logic [5:0]           name_length;
    logic [5:0]           station_length;
    logic [7:0]           record_count;
    logic [TEXT_BITS-1:0] name_text;
    logic [TEXT_BITS-1:0] station_text;
  } result_t;

endpackage

@@ sv/at_slp_parser.sv @@
module at_slp_parser import at_slp_pkg::*; #(
  parameter int TEXT_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_value,
  input  logic       end_of_buffer,
  output logic       emit,
  output result_t    result
);

  localparam int STORE_BYTES = (TEXT_BYTES < OUT_TEXT_BYTES) ? TEXT_BYTES : OUT_TEXT_BYTES;
  localparam int RAW_CAP     = TEXT_BYTES + 2;
  localparam int RAW_W       = $clog2(RAW_CAP + 1);
  localparam int IDX_W       = $clog2(STORE_BYTES);

  logic [2:0]       prefix_pos, prefix_pos_next;
  logic             in_record, in_record_next;
  logic [2:0]       field_index, field_index_next;
  logic [15:0]      number_acc [4];
  logic [15:0]      number_acc_next [4];
  logic [3:0]       number_negative, number_negative_next;
  phase_t           number_phase, number_phase_next;
  logic [RAW_W-1:0] raw_lengths [2];
  logic [RAW_W-1:0] raw_lengths_next [2];
  logic [7:0]       records_done, records_done_next;
  logic [7:0]       name_store [STORE_BYTES];
  logic [7:0]       station_store [STORE_BYTES];

  logic             is_digit, is_blank, is_number, is_text;
  logic [1:0]       num_slot;
  logic             text_slot;
  logic [15:0]      digit_value, acc_sel;
  logic [19:0]      acc_times_ten;
  logic [15:0]      acc_step;
  logic [RAW_W-1:0] raw_sel;
  logic             store_we;
  logic [IDX_W-1:0] store_idx;
  logic [7:0]       count_inc;
  logic [RAW_W-1:0] name_len, station_len;
  logic [TEXT_BITS-1:0] name_text, station_text;

  function automatic logic [RAW_W-1:0] stripped_len(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] n;
    n = raw - RAW_W'(2);
    if (raw < RAW_W'(2)) return '0;
    if (n > RAW_W'(TEXT_BYTES)) return RAW_W'(TEXT_BYTES);
    return n;
  endfunction

  function automatic logic [15:0] number_value(input logic [15:0] a, input logic neg);
    if (neg) return 16'(16'd0 - a);
    if (a > NUM_MAX) return NUM_MAX;
    return a;
  endfunction

  assign is_digit = (byte_value >= CHAR_ZERO) && (byte_value <= CHAR_NINE);
  assign is_blank = (byte_value == CHAR_SPACE) ||
                    ((byte_value >= CHAR_TAB) && (byte_value <= CHAR_CR));
  assign digit_value = {8'd0, byte_value - CHAR_ZERO};
  assign count_inc = (records_done == COUNT_MAX) ? records_done : records_done + 8'd1;

  always_comb begin
    is_number = 1'b0;
    is_text   = 1'b0;
    num_slot  = SLOT_ENCRYPTION;
    text_slot = 1'b0;
    unique case (field_index)
      F_ENCRYPTION: begin
        is_number = 1'b1;
        num_slot  = SLOT_ENCRYPTION;
      end
      F_NAME: begin
        is_text   = 1'b1;
        text_slot = 1'b0;
      end
      F_SIGNAL: begin
        is_number = 1'b1;
        num_slot  = SLOT_SIGNAL;
      end
      F_STATION: begin
        is_text   = 1'b1;
        text_slot = 1'b1;
      end
      F_CHANNEL: begin
        is_number = 1'b1;
        num_slot  = SLOT_CHANNEL;
      end
      F_OFFSET: begin
        is_number = 1'b1;
        num_slot  = SLOT_OFFSET;
      end
      default: begin
        is_number = 1'b0;
      end
    endcase
  end

  assign acc_sel       = number_acc[num_slot];
  assign acc_times_ten = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} + {4'd0, digit_value};
  assign acc_step      = (acc_times_ten > {4'd0, NUM_CAP}) ? NUM_CAP : acc_times_ten[15:0];
  assign raw_sel       = raw_lengths[text_slot];
  assign store_idx     = IDX_W'(raw_sel - RAW_W'(1));

  always_comb begin
    prefix_pos_next      = prefix_pos;
    in_record_next       = in_record;
    field_index_next     = field_index;
    number_acc_next      = number_acc;
    number_negative_next = number_negative;
    number_phase_next    = number_phase;
    raw_lengths_next     = raw_lengths;
    records_done_next    = records_done;
    store_we             = 1'b0;

    if (accept) begin
      if (end_of_buffer) begin
        prefix_pos_next      = '0;
        in_record_next       = 1'b0;
        field_index_next     = '0;
        number_acc_next      = '{default: '0};
        number_negative_next = '0;
        number_phase_next    = PH_BLANK;
        raw_lengths_next     = '{default: '0};
        records_done_next    = '0;
      end else if (!in_record) begin
        if (byte_value == SCAN_PREFIX[prefix_pos]) begin
          if (prefix_pos == 3'(PREFIX_LEN - 1)) begin
            prefix_pos_next      = '0;
            in_record_next       = 1'b1;
            field_index_next     = '0;
            number_acc_next      = '{default: '0};
            number_negative_next = '0;
            number_phase_next    = PH_BLANK;
            raw_lengths_next     = '{default: '0};
          end else begin
            prefix_pos_next = prefix_pos + 3'd1;
          end
        end else begin
          prefix_pos_next = (byte_value == CHAR_PLUS) ? 3'd1 : 3'd0;
        end
      end else if (byte_value == CHAR_CLOSE) begin
        in_record_next    = 1'b0;
        records_done_next = count_inc;
      end else if (field_index < FIELD_COUNT) begin
        if (byte_value == CHAR_COMMA) begin
          field_index_next  = field_index + 3'd1;
          number_phase_next = PH_BLANK;
        end else if (is_number) begin
          unique case (number_phase)
            PH_BLANK: begin
              if (is_blank) begin
                number_phase_next = PH_BLANK;
              end else if (byte_value == CHAR_PLUS || byte_value == CHAR_MINUS) begin
                number_negative_next[num_slot] = (byte_value == CHAR_MINUS);
                number_phase_next = PH_DIGITS;
              end else if (is_digit) begin
                number_acc_next[num_slot] = digit_value;
                number_phase_next = PH_DIGITS;
              end else begin
                number_phase_next = PH_DONE;
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                number_acc_next[num_slot] = acc_step;
              end else begin
                number_phase_next = PH_DONE;
              end
            end
            PH_DONE: begin
              number_phase_next = PH_DONE;
            end
            default: begin
              number_phase_next = number_phase;
            end
          endcase
        end else if (is_text) begin
          // The first raw byte is the opening quote and is not stored
          store_we = (raw_sel != '0) && ((raw_sel - RAW_W'(1)) < RAW_W'(STORE_BYTES));
          if (raw_sel < RAW_W'(RAW_CAP)) begin
            raw_lengths_next[text_slot] = raw_sel + RAW_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pos      <= '0;
      in_record       <= 1'b0;
      field_index     <= '0;
      number_acc      <= '{default: '0};
      number_negative <= '0;
      number_phase    <= PH_BLANK;
      raw_lengths     <= '{default: '0};
      records_done    <= '0;
    end else begin
      prefix_pos      <= prefix_pos_next;
      in_record       <= in_record_next;
      field_index     <= field_index_next;
      number_acc      <= number_acc_next;
      number_negative <= number_negative_next;
      number_phase    <= number_phase_next;
      raw_lengths     <= raw_lengths_next;
      records_done    <= records_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we && !text_slot) begin
      name_store[store_idx] <= byte_value;
    end
    if (store_we && text_slot) begin
      station_store[store_idx] <= byte_value;
    end
  end

  assign name_len    = stripped_len(raw_lengths[0]);
  assign station_len = stripped_len(raw_lengths[1]);

  // Bytes past the stripped length read as zero
  for (genvar b = 0; b < OUT_TEXT_BYTES; b++) begin : g_text
    if (b < STORE_BYTES) begin : g_live
      assign name_text[8*b +: 8]    = (RAW_W'(b) < name_len) ? name_store[b] : 8'd0;
      assign station_text[8*b +: 8] = (RAW_W'(b) < station_len) ? station_store[b] : 8'd0;
    end else begin : g_pad
      assign name_text[8*b +: 8]    = 8'd0;
      assign station_text[8*b +: 8] = 8'd0;
    end
  end

  assign emit = end_of_buffer || (in_record && byte_value == CHAR_CLOSE);

  always_comb begin
    result = '0;
    if (end_of_buffer) begin
      result.kind         = 1'b1;
      result.record_count = records_done;
    end else begin
      result.kind            = 1'b0;
      result.encryption      = number_value(number_acc[SLOT_ENCRYPTION],
                                            number_negative[SLOT_ENCRYPTION]);
      result.signal_strength = number_value(number_acc[SLOT_SIGNAL],
                                            number_negative[SLOT_SIGNAL]);
      result.channel         = number_value(number_acc[SLOT_CHANNEL],
                                            number_negative[SLOT_CHANNEL]);
      result.freq_offset     = number_value(number_acc[SLOT_OFFSET],
                                            number_negative[SLOT_OFFSET]);
      result.name_length     = 6'(name_len);
      result.station_length  = 6'(station_len);
      result.record_count    = count_inc;
      result.name_text       = name_text;
      result.station_text    = station_text;
    end
  end

endmodule

@@ sv/at_scan_list_parser_core.sv @@
// Access-point scan list parser.
// Input channel: one reply byte per transaction (byte_value), or an end marker
// (end_of_buffer high, byte ignored). Output channel: result transactions.
// The parser hunts for "+CWLAP:(" and collects one record up to ')'. A closing
// ')' produces eight record words (word_index 0-3 name text, 4-7 station text,
// the numeric fields and lengths repeated on each, last on word 7). The end
// marker produces one terminator (kind 1, last 1) carrying the record count,
// then all parser state returns to its reset values.
// A result is registered and appears in the cycle after the transaction that causes it.
// Throughput: one input byte per cycle. The eight words of a record leave one
// per cycle from a snapshot register, so input bytes keep flowing meanwhile;
// only a ')' or an end marker that arrives before the previous burst has
// handed over its final word is held by in_stall.
// When the receiver stalls, the current word holds and later words wait.
// Reset (rst, synchronous) clears the parser state and drops any pending
// output words.
module at_scan_list_parser_core import at_slp_pkg::*; #(
  parameter int TEXT_BYTES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         byte_value,
  input  logic               end_of_buffer,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic signed [15:0] encryption,
  output logic signed [15:0] signal_strength,
  output logic signed [15:0] channel,
  output logic signed [15:0] freq_offset,
  output logic [5:0]         name_length,
  output logic [5:0]         station_length,
  output logic [2:0]         word_index,
  output logic [63:0]        text_word,
  output logic               last,
  output logic [7:0]         record_count
);

  logic    in_accept, emit, out_free, load;
  result_t parsed, held;
  logic [2:0] word;
  logic [7:0] word_offset;

  assign last      = held.kind || (word == LAST_WORD);
  assign out_free  = !out_valid || (!out_stall && last);
  assign in_stall  = emit && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign load      = in_accept && emit;

  at_slp_parser #(
    .TEXT_BYTES(TEXT_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .byte_value   (byte_value),
    .end_of_buffer(end_of_buffer),
    .emit         (emit),
    .result       (parsed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      word      <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      word      <= '0;
    end else if (out_valid && !out_stall) begin
      if (last) begin
        out_valid <= 1'b0;
      end else begin
        word <= word + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= parsed;
    end
  end

  assign word_offset = {word[1:0], 6'd0};

  assign kind            = held.kind;
  assign encryption      = held.encryption;
  assign signal_strength = held.signal_strength;
  assign channel         = held.channel;
  assign freq_offset     = held.freq_offset;
  assign name_length     = held.name_length;
  assign station_length  = held.station_length;
  assign record_count    = held.record_count;
  assign word_index      = held.kind ? 3'd0 : word;
  assign text_word       = held.kind ? 64'd0 :
                           word[2] ? held.station_text[word_offset +: 64]
                                   : held.name_text[word_offset +: 64];

endmodule
